@@ hdl/mmts_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and sizes for the min/max tracking stack.
// No dependencies; every other file but mmts_ram imports this package.
package mmts_pkg;

    localparam int DEPTH      = 1024;
    localparam int LVL_W      = $clog2(DEPTH + 1);
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int WORD_W     = 32;
    localparam int FIFO_DEPTH = 2;
    localparam int QPTR_W     = $clog2(FIFO_DEPTH);
    localparam int QCNT_W     = $clog2(FIFO_DEPTH + 1);

    localparam logic [2:0] FN_PUSH = 3'd0;
    localparam logic [2:0] FN_POP  = 3'd1;
    localparam logic [2:0] FN_TOP  = 3'd2;
    localparam logic [2:0] FN_MAX  = 3'd3;
    localparam logic [2:0] FN_MIN  = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    // work kinds handed from front to back
    localparam logic [1:0] K_NONE = 2'd0;
    localparam logic [1:0] K_PUSH = 2'd1;
    localparam logic [1:0] K_READ = 2'd2;

    typedef struct packed {
        logic [2:0]               func;
        logic signed [WORD_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [WORD_W-1:0] data;
    } res_t;

    typedef struct packed {
        logic [1:0]               kind;
        logic [2:0]               func;
        logic [1:0]               status;
        logic                     first;
        logic [ADDR_W-1:0]        addr;
        logic signed [WORD_W-1:0] value;
    } op_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] entry;
        logic signed [WORD_W-1:0] max;
        logic signed [WORD_W-1:0] min;
    } level_t;

    localparam int LEVEL_W = $bits(level_t);

endpackage

@@ hdl/min_max_tracking_stack.sv @@
`timescale 1ns / 1ps
// Top level of the min/max tracking stack: front, request queue, back.
// Depends on mmts_pkg, mmts_front, mmts_fifo, mmts_back (and mmts_ram).
//
//  channel   handshake        payload   notes
//  command   start & !busy    cmd       func, value
//  result    done (1 cycle)   result    status, data
//
// A request is taken in any cycle where busy is low; busy rises only when the
// queue holds two requests. A pop, error, unused code or push onto an empty stack
// gets its result in the cycle after the back part takes it; a read or other
// push waits in S_WAIT for the registered memory read, while the back part takes
// nothing new. Reset clears the fill level, the queue and the back state; the
// level memory needs no clearing. The receiver cannot stall; results never wait.
module min_max_tracking_stack (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  mmts_pkg::cmd_t cmd,
    output logic           busy,
    output logic           done,
    output mmts_pkg::res_t result
);
    import mmts_pkg::*;

    logic q_push;
    logic q_pop;
    logic q_empty;
    logic q_full;
    op_t  q_op;
    op_t  q_head;

    mmts_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .q_full (q_full),
        .busy   (busy),
        .q_push (q_push),
        .q_op   (q_op)
    );

    mmts_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_op),
        .pop   (q_pop),
        .head  (q_head),
        .empty (q_empty),
        .full  (q_full)
    );

    mmts_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .done    (done),
        .result  (result)
    );

endmodule

@@ hdl/mmts_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mmts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/mmts_fifo.sv @@
`timescale 1ns / 1ps
// Short request queue between the front and back parts.
// Depends on mmts_pkg.
module mmts_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mmts_pkg::op_t wdata,
    input  logic          pop,
    output mmts_pkg::op_t head,
    output logic          empty,
    output logic          full
);
    import mmts_pkg::*;

    op_t               mem_reg [FIFO_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == QCNT_W'(FIFO_DEPTH));
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ hdl/mmts_front.sv @@
`timescale 1ns / 1ps
// Front part: takes commands, keeps the fill level and classifies each request.
// Depends on mmts_pkg.
module mmts_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  mmts_pkg::cmd_t cmd,
    input  logic           q_full,
    output logic           busy,
    output logic           q_push,
    output mmts_pkg::op_t  q_op
);
    import mmts_pkg::*;

    logic [LVL_W-1:0] fill_reg, fill_next;
    logic             is_empty;
    logic             is_full;

    assign busy     = q_full;
    assign q_push   = start && !q_full;
    assign is_empty = (fill_reg == '0);
    assign is_full  = (fill_reg == LVL_W'(DEPTH));

    always_comb
    begin
        fill_next    = fill_reg;
        q_op.kind    = K_NONE;
        q_op.func    = cmd.func;
        q_op.status  = ST_OK;
        q_op.first   = is_empty;
        q_op.addr    = fill_reg[ADDR_W-1:0];
        q_op.value   = cmd.value;
        case (cmd.func)
            FN_PUSH:
            begin
                if (is_full)
                begin
                    q_op.status = ST_OVERFLOW;
                end
                else
                begin
                    q_op.kind = K_PUSH;
                    fill_next = fill_reg + 1'b1;
                end
            end
            FN_POP:
            begin
                if (is_empty)
                begin
                    q_op.status = ST_UNDERFLOW;
                end
                else
                begin
                    fill_next = fill_reg - 1'b1;
                end
            end
            FN_TOP, FN_MAX, FN_MIN:
            begin
                if (is_empty)
                begin
                    q_op.status = ST_EMPTY;
                end
                else
                begin
                    q_op.kind = K_READ;
                    q_op.addr = fill_reg[ADDR_W-1:0] - 1'b1;
                end
            end
            default:
            begin
                q_op.kind = K_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (q_push)
        begin
            fill_reg <= fill_next;
        end
    end

endmodule

@@ hdl/mmts_back.sv @@
`timescale 1ns / 1ps
// Back part: carries out queued requests against the level memory, drives results.
// Depends on mmts_pkg and mmts_ram.
module mmts_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  mmts_pkg::op_t  q_head,
    output logic           q_pop,
    output logic           done,
    output mmts_pkg::res_t result
);
    import mmts_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_WAIT = 1'b1;

    logic              state_reg, state_next;
    op_t               op_reg, op_next;
    logic              done_reg, done_next;
    res_t              result_reg, result_next;

    logic              we;
    logic [ADDR_W-1:0] waddr;
    level_t            wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
    level_t            rdata;
    logic [LEVEL_W-1:0] rdata_raw;

    mmts_ram #(
        .WIDTH (LEVEL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata_raw)
    );

    assign rdata = level_t'(rdata_raw);

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        q_pop       = 1'b0;
        we          = 1'b0;
        waddr       = op_reg.addr;
        wdata       = '{entry: op_reg.value, max: op_reg.value, min: op_reg.value};
        re          = 1'b0;
        raddr       = q_head.addr;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop   = 1'b1;
                    op_next = q_head;
                    case (q_head.kind)
                        K_PUSH:
                        begin
                            if (q_head.first)
                            begin
                                we        = 1'b1;
                                waddr     = q_head.addr;
                                wdata     = '{entry: q_head.value, max: q_head.value,
                                              min: q_head.value};
                                done_next = 1'b1;
                                result_next = '{status: ST_OK, data: '0};
                            end
                            else
                            begin
                                // fetch the level below for the running extrema
                                re         = 1'b1;
                                raddr      = q_head.addr - 1'b1;
                                state_next = S_WAIT;
                            end
                        end
                        K_READ:
                        begin
                            re         = 1'b1;
                            state_next = S_WAIT;
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            result_next = '{status: q_head.status, data: '0};
                        end
                    endcase
                end
            end
            S_WAIT:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (op_reg.kind == K_PUSH)
                begin
                    we        = 1'b1;
                    wdata.max = (op_reg.value > rdata.max) ? op_reg.value : rdata.max;
                    wdata.min = (rdata.min > op_reg.value) ? op_reg.value : rdata.min;
                    result_next = '{status: ST_OK, data: '0};
                end
                else
                begin
                    case (op_reg.func)
                        FN_TOP:  result_next = '{status: ST_OK, data: rdata.entry};
                        FN_MAX:  result_next = '{status: ST_OK, data: rdata.max};
                        default: result_next = '{status: ST_OK, data: rdata.min};
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ hdl/mmts_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the min/max tracking stack, bound to the top level.
// Depends on mmts_pkg and min_max_tracking_stack.
module mmts_props (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           done,
    input mmts_pkg::res_t result
);
    import mmts_pkg::*;

    logic       accept;
    logic [2:0] pend_reg, pend_next;

    assign accept = start && !busy;

    always_comb
    begin
        pend_next = pend_reg;
        if (accept && !done)
        begin
            pend_next = pend_reg + 1'b1;
        end
        else if (done && !accept)
        begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_no_orphan_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> pend_reg != 3'd0)
        else $error("result without an outstanding request");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 3'd4)
        else $error("too many requests in flight");

    a_data_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != ST_OK |-> result.data == '0)
        else $error("nonzero data with error status");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a request");

endmodule

bind min_max_tracking_stack mmts_props u_mmts_props (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

@@ verif/mmts_checker.sv @@
`timescale 1ns / 1ps
// Checker for the min/max tracking stack: watches the command and result ports.
// It predicts each result from its own copy of the stack and compares it.
// Depends on mmts_pkg.
module mmts_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           busy,
    input  mmts_pkg::cmd_t cmd,
    input  logic           done,
    input  mmts_pkg::res_t result,
    input  logic           wrap_up,
    output int             errors,
    output int             pending,
    output int             peak_level,
    output int             n_overflow,
    output int             n_underflow,
    output int             n_empty
);
    import mmts_pkg::*;

    localparam int MAX_PRINTS = 40;

    // predicted stack contents: word, running max, running min per level
    logic signed [WORD_W-1:0] stack_word [DEPTH];
    logic signed [WORD_W-1:0] stack_hi   [DEPTH];
    logic signed [WORD_W-1:0] stack_lo   [DEPTH];
    int                       fill = 0;

    res_t                     expected_res [$];
    int                       n_results = 0;
    logic                     wrapped = 1'b0;

    initial
    begin
        errors      = 0;
        pending     = 0;
        peak_level  = 0;
        n_overflow  = 0;
        n_underflow = 0;
        n_empty     = 0;
    end

    task automatic report(input string msg);
        if (errors < MAX_PRINTS)
            $display("%0t mmts_checker: %s", $time, msg);
        errors++;
    endtask

    function automatic res_t stack_apply(cmd_t c);
        res_t                     r;
        logic signed [WORD_W-1:0] hi;
        logic signed [WORD_W-1:0] lo;
        r.status = ST_OK;
        r.data   = '0;
        case (c.func)
            FN_PUSH:
            begin
                if (fill == DEPTH)
                    r.status = ST_OVERFLOW;
                else
                begin
                    hi = c.value;
                    lo = c.value;
                    if (fill > 0)
                    begin
                        if (stack_hi[fill-1] > hi)
                            hi = stack_hi[fill-1];
                        if (stack_lo[fill-1] < lo)
                            lo = stack_lo[fill-1];
                    end
                    stack_word[fill] = c.value;
                    stack_hi[fill]   = hi;
                    stack_lo[fill]   = lo;
                    fill++;
                    if (fill > peak_level)
                        peak_level = fill;
                end
            end
            FN_POP:
            begin
                if (fill == 0)
                    r.status = ST_UNDERFLOW;
                else
                    fill--;
            end
            FN_TOP, FN_MAX, FN_MIN:
            begin
                if (fill == 0)
                    r.status = ST_EMPTY;
                else if (c.func == FN_TOP)
                    r.data = stack_word[fill-1];
                else if (c.func == FN_MAX)
                    r.data = stack_hi[fill-1];
                else
                    r.data = stack_lo[fill-1];
            end
            default: ;  // unused codes leave the stack alone
        endcase
        return r;
    endfunction

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n)
        begin
            // results first: a result never belongs to a request taken this edge
            if (done)
            begin
                n_results++;
                if (expected_res.size() == 0)
                    report($sformatf("result %0d with no request outstanding: status %0d data %0d",
                                     n_results, result.status, result.data));
                else
                begin
                    want = expected_res.pop_front();
                    if (result.status !== want.status)
                        report($sformatf("result %0d status %0d, want %0d",
                                         n_results, result.status, want.status));
                    if (result.data !== want.data)
                        report($sformatf("result %0d data %0d, want %0d",
                                         n_results, result.data, want.data));
                    case (want.status)
                        ST_OVERFLOW:  n_overflow++;
                        ST_UNDERFLOW: n_underflow++;
                        ST_EMPTY:     n_empty++;
                        default: ;
                    endcase
                end
            end
            if (start && !busy)
                expected_res.push_back(stack_apply(cmd));
            if (wrap_up && !wrapped)
            begin
                wrapped = 1'b1;
                if (expected_res.size() != 0)
                    report($sformatf("%0d results never arrived", expected_res.size()));
            end
            pending = expected_res.size();
        end
    end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top for the min/max tracking stack: clock, reset, command stimulus.
// Depends on mmts_pkg, min_max_tracking_stack and mmts_checker.
module tb_top;
    import mmts_pkg::*;

    localparam int          CYCLE_LIMIT     = 100000;
    localparam int          PHASE_ITEMS     = 90;
    localparam logic [2:0]  FN_UNUSED_FIRST = 3'd5;
    localparam logic [2:0]  FN_UNUSED_LAST  = 3'd7;

    typedef enum int { MODE_MIX, MODE_GROW, MODE_DRAIN } mode_t;

    logic  clk;
    logic  rst_n;
    logic  start;
    cmd_t  cmd;
    logic  busy;
    logic  done;
    res_t  result;
    logic  wrap_up;

    int    errors;
    int    pending;
    int    peak_level;
    int    n_overflow;
    int    n_underflow;
    int    n_empty;

    int    idle_pct = 0;
    int    n_sent   = 0;
    int    cycles   = 0;

    min_max_tracking_stack u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    mmts_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .done        (done),
        .result      (result),
        .wrap_up     (wrap_up),
        .errors      (errors),
        .pending     (pending),
        .peak_level  (peak_level),
        .n_overflow  (n_overflow),
        .n_underflow (n_underflow),
        .n_empty     (n_empty)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_top: timeout after %0d cycles, %0d requests outstanding", cycles, pending);
        $display("tb_top: done, errors");
        $finish;
    end

    // mostly random bits, with extremes and small values so max/min move
    function automatic logic signed [WORD_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return {1'b0, {(WORD_W-1){1'b1}}};
            1: return {1'b1, {(WORD_W-1){1'b0}}};
            2: return $signed($urandom_range(20)) - 10;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_read();
        return FN_TOP + 3'($urandom_range(2));
    endfunction

    function automatic logic [2:0] pick_func(mode_t m);
        int roll;
        roll = $urandom_range(99);
        if (roll < 4)
            return 3'($urandom_range(FN_UNUSED_FIRST, FN_UNUSED_LAST));
        case (m)
            MODE_GROW:  return (roll < 65) ? FN_PUSH : (roll < 80) ? FN_POP : pick_read();
            MODE_DRAIN: return (roll < 20) ? FN_PUSH : (roll < 75) ? FN_POP : pick_read();
            default:    return (roll < 40) ? FN_PUSH : (roll < 70) ? FN_POP : pick_read();
        endcase
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic issue(input logic [2:0] f, input logic signed [WORD_W-1:0] v);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= '{func: f, value: v};
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        n_sent++;
    endtask

    task automatic random_run(input int n_items);
        mode_t mode;
        int    left;
        mode = MODE_MIX;
        left = 0;
        repeat (n_items)
        begin
            if (left == 0)
            begin
                mode = mode_t'($urandom_range(MODE_DRAIN));
                left = $urandom_range(10, 40);
            end
            left--;
            issue(pick_func(mode), pick_value());
        end
    endtask

    initial
    begin
        int pushes;
        rst_n   = 1'b0;
        start   = 1'b0;
        cmd     = '0;
        wrap_up = 1'b0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty cases, unused codes, word extremes, unwind to underflow
        issue(FN_POP, pick_value());
        issue(FN_TOP, pick_value());
        issue(FN_MAX, pick_value());
        issue(FN_MIN, pick_value());
        issue(FN_UNUSED_FIRST, pick_value());
        issue(FN_UNUSED_FIRST + 3'd1, pick_value());
        issue(FN_UNUSED_LAST, pick_value());
        issue(FN_PUSH, '0);
        issue(FN_PUSH, {1'b0, {(WORD_W-1){1'b1}}});
        issue(FN_PUSH, {1'b1, {(WORD_W-1){1'b0}}});
        issue(FN_TOP, '0);
        issue(FN_MAX, '0);
        issue(FN_MIN, '0);
        issue(FN_PUSH, -1);
        issue(FN_PUSH, 1);
        issue(FN_TOP, '0);
        issue(FN_MAX, '0);
        issue(FN_MIN, '0);
        issue(FN_POP, '0);
        issue(FN_POP, '0);
        issue(FN_TOP, '0);
        issue(FN_MAX, '0);
        issue(FN_MIN, '0);
        repeat (4) issue(FN_POP, '0);

        // random phases; the receiver cannot stall, so only the sender idles
        idle_pct = 0;
        random_run(PHASE_ITEMS);
        idle_pct = 70;
        random_run(PHASE_ITEMS);
        idle_pct = 0;
        random_run(PHASE_ITEMS);

        // climb past full with reads mixed in, then knock at the ceiling
        idle_pct = 23;
        pushes   = 0;
        while (pushes < DEPTH + 6)
        begin
            if ($urandom_range(99) < 8)
                issue(pick_read(), pick_value());
            else
            begin
                issue(FN_PUSH, pick_value());
                pushes++;
            end
        end
        random_run(40);

        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        wrap_up <= 1'b1;
        @(negedge clk);
        @(negedge clk);

        $display("tb_top: %0d commands in %0d cycles, peak stack level %0d of %0d",
                 n_sent, cycles, peak_level, DEPTH);
        $display("tb_top: overflow %0d, underflow %0d, empty reads %0d",
                 n_overflow, n_underflow, n_empty);
        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/mmts_pkg.sv
hdl/mmts_ram.sv
hdl/mmts_fifo.sv
hdl/mmts_front.sv
hdl/mmts_back.sv
hdl/min_max_tracking_stack.sv
hdl/mmts_checker.sv
verif/mmts_checker.sv
verif/tb_top.sv
